### rtl/imds_pkg.sv
// Package for the I2C motor/DAC sequencer: command and step codes, bus constants
// and the result record. Used by i2c_motor_dac_sequencer_core; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package imds_pkg;

  localparam int NUM_CONTROLLERS = 4;
  localparam int IDX_W           = 2;
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(NUM_CONTROLLERS - 1);

  localparam logic [7:0] ADDR_MOTOR_WR = 8'h52;
  localparam logic [7:0] ADDR_MOTOR_RD = 8'h53;
  localparam logic [7:0] ADDR_DAC      = 8'h98;
  localparam logic [7:0] DAC_SEL_BASE  = 8'h10;
  localparam logic [7:0] DAC_FIXED     = 8'h80;
  localparam logic [1:0] DAC_LAST_CHAN = 2'd2;

  typedef enum logic [1:0] {
    OP_EVENT = 2'd0,
    OP_MOTOR = 2'd1,
    OP_DAC   = 2'd2,
    OP_RESET = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CMD_WRITE   = 3'd0,
    CMD_START   = 3'd1,
    CMD_STOP    = 3'd2,
    CMD_RX_ACK  = 3'd3,
    CMD_RX_NACK = 3'd4
  } bus_cmd_t;

  typedef enum logic [3:0] {
    ST_MOT_ADDR  = 4'd0,
    ST_MOT_DATA  = 4'd1,
    ST_MOT_STOP  = 4'd2,
    ST_RD_ADDR   = 4'd3,
    ST_RD_ACK    = 4'd4,
    ST_RD_NACK   = 4'd5,
    ST_RD_STOP   = 4'd6,
    ST_DAC_ADDR  = 4'd7,
    ST_DAC_SEL   = 4'd8,
    ST_DAC_OFFS  = 4'd9,
    ST_DAC_FIXED = 4'd10,
    ST_DAC_STOP  = 4'd11
  } step_t;

  typedef struct packed {
    bus_cmd_t   cmd;
    logic [7:0] tx;
    logic       reload;
    logic       stored;
    logic [2:0] slot;
    logic [7:0] value;
    logic       last;
  } res_t;

  // Builds one bus command; the byte fields are zero where they carry no meaning.
  function automatic res_t mk_res(bus_cmd_t cmd, logic [7:0] tx, logic reload,
                                  logic stored, logic [2:0] slot, logic [7:0] value);
    res_t r;
    r.cmd    = cmd;
    r.tx     = (cmd == CMD_WRITE) ? tx : 8'd0;
    r.reload = reload;
    r.stored = stored;
    r.slot   = stored ? slot : 3'd0;
    r.value  = stored ? value : 8'd0;
    r.last   = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/i2c_motor_dac_sequencer_core.sv
// I2C master transaction sequencer for four motor controllers and a gyro-offset DAC.
// An item is taken into an input register; once the result buffer is free, its first
// bus command is registered on the output, followed by up to two more, one per cycle
// while out_tready is high. An item causes 1 to 3 bus commands on the single output
// port; the next item waits in the input register meanwhile. Reset (rst_n low,
// synchronous) returns the sequencer to the first motor address step, indices at zero.
`timescale 1ns / 1ps
`default_nettype none

module i2c_motor_dac_sequencer_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [7:0] rx_byte, [15:8] front_cmd, [23:16] rear_cmd, [31:24] right_cmd,
  // [39:32] left_cmd, [47:40] offset_pitch, [55:48] offset_roll, [63:56] offset_yaw
  input  wire logic [63:0] in_tdata,
  // [1:0] op
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [2:0] bus_cmd, [10:3] tx_byte, [11] timeout_reload, [12] rx_stored,
  // [15:13] rx_slot, [23:16] rx_value
  output logic [23:0]      out_tdata,
  output logic             out_tlast
);

  // Input register.
  logic                   inv_r;
  logic [63:0]            in_data_r;
  imds_pkg::op_t          in_op_r;

  // Sequencer state.
  imds_pkg::step_t        step_r, step_nxt;
  logic [imds_pkg::IDX_W-1:0] wi_r, wi_nxt;
  logic [imds_pkg::IDX_W-1:0] ri_r, ri_nxt;
  logic [1:0]             di_r, di_nxt;

  // Result buffer, head at entry zero.
  imds_pkg::res_t         res_r [3];
  imds_pkg::res_t         res_nxt [3];
  logic [1:0]             cnt_r, cnt_nxt;

  imds_pkg::res_t         r0, r1, r2;
  logic [1:0]             n_res;
  logic                   out_fire, buf_free, move;

  logic [7:0] rx_byte, motor_sel, offs_sel;

  // The receive store is only ever written, so it is not kept here: every stored
  // byte leaves on the result channel together with its slot.

  assign out_fire  = out_tvalid && out_tready;
  assign buf_free  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_tready);
  assign move      = inv_r && buf_free;
  assign in_tready = !inv_r || move;

  assign rx_byte = in_data_r[7:0];

  always_comb begin
    case (wi_r)
      2'd0:    motor_sel = in_data_r[15:8];
      2'd1:    motor_sel = in_data_r[23:16];
      2'd2:    motor_sel = in_data_r[31:24];
      default: motor_sel = in_data_r[39:32];
    endcase
    case (di_r)
      2'd0:    offs_sel = in_data_r[47:40];
      2'd1:    offs_sel = in_data_r[55:48];
      2'd2:    offs_sel = in_data_r[63:56];
      default: offs_sel = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      inv_r <= 1'b1;
    end else if (move) begin
      inv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_data_r <= in_tdata;
      in_op_r   <= imds_pkg::op_t'(in_tuser);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= imds_pkg::ST_MOT_ADDR;
      wi_r   <= '0;
      ri_r   <= '0;
      di_r   <= '0;
    end else if (move) begin
      step_r <= step_nxt;
      wi_r   <= wi_nxt;
      ri_r   <= ri_nxt;
      di_r   <= di_nxt;
    end
  end

  // Next step and the bus commands for the item in the input register.
  always_comb begin
    step_nxt = step_r;
    wi_nxt   = wi_r;
    ri_nxt   = ri_r;
    di_nxt   = di_r;
    r0 = imds_pkg::mk_res(imds_pkg::CMD_STOP, 8'd0, 1'b0, 1'b0, 3'd0, 8'd0);
    r1 = imds_pkg::mk_res(imds_pkg::CMD_START, 8'd0, 1'b0, 1'b0, 3'd0, 8'd0);
    r2 = imds_pkg::mk_res(imds_pkg::CMD_WRITE, 8'd0, 1'b0, 1'b0, 3'd0, 8'd0);
    n_res = 2'd1;
    unique case (in_op_r)
      imds_pkg::OP_MOTOR: begin
        step_nxt = imds_pkg::ST_MOT_ADDR;
        wi_nxt   = '0;
        r0 = imds_pkg::mk_res(imds_pkg::CMD_START, 8'd0, 1'b0, 1'b0, 3'd0, 8'd0);
      end
      imds_pkg::OP_DAC: begin
        step_nxt = imds_pkg::ST_DAC_ADDR;
        di_nxt   = 2'd0;
        r0 = imds_pkg::mk_res(imds_pkg::CMD_START, 8'd0, 1'b0, 1'b0, 3'd0, 8'd0);
      end
      imds_pkg::OP_RESET: begin
        step_nxt = imds_pkg::ST_MOT_ADDR;
        wi_nxt   = '0;
        ri_nxt   = '0;
        n_res    = 2'd3;
      end
      default: begin
        unique case (step_r)
          imds_pkg::ST_MOT_ADDR: begin
            step_nxt = imds_pkg::ST_MOT_DATA;
            r0 = imds_pkg::mk_res(imds_pkg::CMD_WRITE,
                                  imds_pkg::ADDR_MOTOR_WR + {5'd0, wi_r, 1'b0},
                                  1'b0, 1'b0, 3'd0, 8'd0);
          end
          imds_pkg::ST_MOT_DATA: begin
            step_nxt = imds_pkg::ST_MOT_STOP;
            r0 = imds_pkg::mk_res(imds_pkg::CMD_WRITE, motor_sel, 1'b0, 1'b0, 3'd0, 8'd0);
          end
          imds_pkg::ST_MOT_STOP: begin
            n_res = 2'd2;
            if (wi_r < imds_pkg::IDX_MAX) begin
              wi_nxt   = wi_r + 1'b1;
              step_nxt = imds_pkg::ST_MOT_ADDR;
            end else begin
              wi_nxt   = '0;
              step_nxt = imds_pkg::ST_RD_ADDR;
            end
          end
          imds_pkg::ST_RD_ADDR: begin
            step_nxt = imds_pkg::ST_RD_ACK;
            r0 = imds_pkg::mk_res(imds_pkg::CMD_WRITE,
                                  imds_pkg::ADDR_MOTOR_RD + {5'd0, ri_r, 1'b0},
                                  1'b0, 1'b0, 3'd0, 8'd0);
          end
          imds_pkg::ST_RD_ACK: begin
            step_nxt = imds_pkg::ST_RD_NACK;
            r0 = imds_pkg::mk_res(imds_pkg::CMD_RX_ACK, 8'd0, 1'b0, 1'b0, 3'd0, 8'd0);
          end
          imds_pkg::ST_RD_NACK: begin
            step_nxt = imds_pkg::ST_RD_STOP;
            r0 = imds_pkg::mk_res(imds_pkg::CMD_RX_NACK, 8'd0, 1'b0, 1'b1,
                                  {1'b0, ri_r}, rx_byte);
          end
          imds_pkg::ST_RD_STOP: begin
            step_nxt = imds_pkg::ST_MOT_ADDR;
            ri_nxt   = (ri_r >= imds_pkg::IDX_MAX) ? '0 : ri_r + 1'b1;
            r0 = imds_pkg::mk_res(imds_pkg::CMD_STOP, 8'd0, 1'b1, 1'b1,
                                  {1'b1, ri_r}, rx_byte);
          end
          imds_pkg::ST_DAC_ADDR: begin
            step_nxt = imds_pkg::ST_DAC_SEL;
            r0 = imds_pkg::mk_res(imds_pkg::CMD_WRITE, imds_pkg::ADDR_DAC,
                                  1'b0, 1'b0, 3'd0, 8'd0);
          end
          imds_pkg::ST_DAC_SEL: begin
            step_nxt = imds_pkg::ST_DAC_OFFS;
            r0 = imds_pkg::mk_res(imds_pkg::CMD_WRITE,
                                  imds_pkg::DAC_SEL_BASE + {5'd0, di_r, 1'b0},
                                  1'b0, 1'b0, 3'd0, 8'd0);
          end
          imds_pkg::ST_DAC_OFFS: begin
            step_nxt = imds_pkg::ST_DAC_FIXED;
            r0 = imds_pkg::mk_res(imds_pkg::CMD_WRITE, offs_sel, 1'b0, 1'b0, 3'd0, 8'd0);
          end
          imds_pkg::ST_DAC_FIXED: begin
            step_nxt = imds_pkg::ST_DAC_STOP;
            r0 = imds_pkg::mk_res(imds_pkg::CMD_WRITE, imds_pkg::DAC_FIXED,
                                  1'b0, 1'b0, 3'd0, 8'd0);
          end
          imds_pkg::ST_DAC_STOP: begin
            r0 = imds_pkg::mk_res(imds_pkg::CMD_STOP, 8'd0, 1'b1, 1'b0, 3'd0, 8'd0);
            if (di_r < imds_pkg::DAC_LAST_CHAN) begin
              di_nxt   = di_r + 1'b1;
              step_nxt = imds_pkg::ST_DAC_ADDR;
              n_res    = 2'd2;
            end else begin
              di_nxt   = 2'd0;
              step_nxt = imds_pkg::ST_MOT_ADDR;
            end
          end
          default: begin
            // A step outside the sequence stops the bus and starts over.
            step_nxt = imds_pkg::ST_MOT_ADDR;
            wi_nxt   = '0;
            ri_nxt   = '0;
            r0 = imds_pkg::mk_res(imds_pkg::CMD_STOP, 8'd0, 1'b1, 1'b0, 3'd0, 8'd0);
          end
        endcase
      end
    endcase
  end

  // Result buffer: shifts towards the head as items leave, reloads on a move.
  always_comb begin
    res_nxt[0] = res_r[0];
    res_nxt[1] = res_r[1];
    res_nxt[2] = res_r[2];
    cnt_nxt    = cnt_r;
    if (out_fire) begin
      res_nxt[0] = res_r[1];
      res_nxt[1] = res_r[2];
      cnt_nxt    = cnt_r - 1'b1;
    end
    if (move) begin
      res_nxt[0] = r0;
      res_nxt[1] = r1;
      res_nxt[2] = r2;
      res_nxt[0].last = (n_res == 2'd1);
      res_nxt[1].last = (n_res == 2'd2);
      res_nxt[2].last = (n_res == 2'd3);
      cnt_nxt = n_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r[0] <= res_nxt[0];
    res_r[1] <= res_nxt[1];
    res_r[2] <= res_nxt[2];
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tlast  = res_r[0].last;
  assign out_tdata  = {res_r[0].value, res_r[0].slot, res_r[0].stored,
                       res_r[0].reload, res_r[0].tx, res_r[0].cmd};

  // The last flag of an item reaches the head only with its final command.
  a_last_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> cnt_r == 2'd1)
    else $error("last flag shown with further commands pending");

  // Every item moved out of the input register yields at least one command.
  a_move_gives_out: assert property (@(posedge clk) disable iff (!rst_n)
    move |=> out_tvalid)
    else $error("item moved without a bus command");

  // A received byte is stored only with the NACK receive or the closing STOP.
  a_store_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res_r[0].stored |->
      res_r[0].cmd == imds_pkg::CMD_RX_NACK || res_r[0].cmd == imds_pkg::CMD_STOP)
    else $error("receive store written by a wrong command");

  // The DAC channel index stays on the three channels.
  a_dac_range: assert property (@(posedge clk) disable iff (!rst_n)
    di_r != 2'd3)
    else $error("DAC channel index out of range");

endmodule

`default_nettype wire

### bench/tb_i2c_motor_dac_sequencer_core.sv
// Self-checking testbench for the I2C motor/DAC sequencer: a directed table, then random
// motor and DAC passes with noise, predicted in the bench. Depends on rtl/imds_pkg.sv and
// rtl/i2c_motor_dac_sequencer_core.sv.
`timescale 1ns / 1ps

module tb_i2c_motor_dac_sequencer_core;

  localparam logic [7:0] MOTOR_WR_ADDR = 8'h52;
  localparam logic [7:0] MOTOR_RD_ADDR = 8'h53;
  localparam logic [7:0] DAC_ADDR      = 8'h98;
  localparam logic [7:0] DAC_SEL       = 8'h10;
  localparam logic [7:0] DAC_TAIL      = 8'h80;
  localparam logic [63:0] DATA_A = {8'h81, 8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h00, 8'hFF, 8'hC3};
  localparam logic [63:0] DATA_B = ~DATA_A;
  localparam int RANDOM_ITEMS = 290;

  typedef struct packed {
    imds_pkg::op_t        op;
    logic [63:0]          data;
    logic [1:0]           n_typed;
    imds_pkg::res_t [2:0] typed;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic [1:0]  in_tuser = imds_pkg::OP_EVENT;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tlast;

  // Bench copy of the sequencer state.
  logic [3:0] seq_step = '0;
  logic [1:0] wr_idx = '0;
  logic [1:0] rd_idx = '0;
  logic [1:0] dac_idx = '0;

  imds_pkg::res_t expected_cmds[$];
  row_t dir_rows[$];
  logic steady = 1'b0;
  int   mismatches = 0;
  int   cmds_checked = 0;
  int   items_sent = 0;
  int   motor_passes = 0;
  int   dac_passes = 0;
  int   rand_count = 0;

  i2c_motor_dac_sequencer_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_i2c_motor_dac_sequencer_core failed");
    $finish;
  end

  function automatic imds_pkg::res_t bus_word(imds_pkg::bus_cmd_t cmd, logic [7:0] tx,
                                              logic reload, logic stored,
                                              logic [2:0] slot, logic [7:0] value,
                                              logic lst);
    imds_pkg::res_t r;
    r.cmd    = cmd;
    r.tx     = tx;
    r.reload = reload;
    r.stored = stored;
    r.slot   = slot;
    r.value  = value;
    r.last   = lst;
    return r;
  endfunction

  // Works out the bus commands caused by one item and advances the bench state.
  function automatic void sequence_bus_cmds(input imds_pkg::op_t op, input logic [63:0] d,
                                            output imds_pkg::res_t [2:0] cmds,
                                            output int n);
    logic [3:0] s;
    logic [7:0] rx;
    logic [7:0] offs_byte;
    cmds = '0;
    n    = 0;
    rx   = d[7:0];
    case (op)
      imds_pkg::OP_MOTOR: begin
        seq_step = imds_pkg::ST_MOT_ADDR;
        wr_idx   = '0;
        cmds[n++] = bus_word(imds_pkg::CMD_START, 8'h00, 1'b0, 1'b0, 3'd0, 8'h00, 1'b0);
      end
      imds_pkg::OP_DAC: begin
        seq_step = imds_pkg::ST_DAC_ADDR;
        dac_idx  = '0;
        cmds[n++] = bus_word(imds_pkg::CMD_START, 8'h00, 1'b0, 1'b0, 3'd0, 8'h00, 1'b0);
      end
      imds_pkg::OP_RESET: begin
        seq_step = imds_pkg::ST_MOT_ADDR;
        wr_idx   = '0;
        rd_idx   = '0;
        cmds[n++] = bus_word(imds_pkg::CMD_STOP, 8'h00, 1'b0, 1'b0, 3'd0, 8'h00, 1'b0);
        cmds[n++] = bus_word(imds_pkg::CMD_START, 8'h00, 1'b0, 1'b0, 3'd0, 8'h00, 1'b0);
        cmds[n++] = bus_word(imds_pkg::CMD_WRITE, 8'h00, 1'b0, 1'b0, 3'd0, 8'h00, 1'b0);
      end
      default: begin
        s        = seq_step;
        seq_step = s + 4'd1;
        case (s)
          imds_pkg::ST_MOT_ADDR:
            cmds[n++] = bus_word(imds_pkg::CMD_WRITE, MOTOR_WR_ADDR + {5'd0, wr_idx, 1'b0},
                                 1'b0, 1'b0, 3'd0, 8'h00, 1'b0);
          imds_pkg::ST_MOT_DATA:
            cmds[n++] = bus_word(imds_pkg::CMD_WRITE, d[8 + 8 * wr_idx +: 8],
                                 1'b0, 1'b0, 3'd0, 8'h00, 1'b0);
          imds_pkg::ST_MOT_STOP: begin
            cmds[n++] = bus_word(imds_pkg::CMD_STOP, 8'h00, 1'b0, 1'b0, 3'd0, 8'h00, 1'b0);
            // The last controller falls through to the read phase.
            if (wr_idx < 2'd3) begin
              wr_idx   = wr_idx + 2'd1;
              seq_step = imds_pkg::ST_MOT_ADDR;
            end else begin
              wr_idx = '0;
            end
            cmds[n++] = bus_word(imds_pkg::CMD_START, 8'h00, 1'b0, 1'b0, 3'd0, 8'h00, 1'b0);
          end
          imds_pkg::ST_RD_ADDR:
            cmds[n++] = bus_word(imds_pkg::CMD_WRITE, MOTOR_RD_ADDR + {5'd0, rd_idx, 1'b0},
                                 1'b0, 1'b0, 3'd0, 8'h00, 1'b0);
          imds_pkg::ST_RD_ACK:
            cmds[n++] = bus_word(imds_pkg::CMD_RX_ACK, 8'h00, 1'b0, 1'b0, 3'd0, 8'h00, 1'b0);
          imds_pkg::ST_RD_NACK:
            cmds[n++] = bus_word(imds_pkg::CMD_RX_NACK, 8'h00, 1'b0, 1'b1, {1'b0, rd_idx},
                                 rx, 1'b0);
          imds_pkg::ST_RD_STOP: begin
            cmds[n++] = bus_word(imds_pkg::CMD_STOP, 8'h00, 1'b1, 1'b1, {1'b1, rd_idx},
                                 rx, 1'b0);
            rd_idx   = rd_idx + 2'd1;
            seq_step = imds_pkg::ST_MOT_ADDR;
          end
          imds_pkg::ST_DAC_ADDR:
            cmds[n++] = bus_word(imds_pkg::CMD_WRITE, DAC_ADDR, 1'b0, 1'b0, 3'd0, 8'h00,
                                 1'b0);
          imds_pkg::ST_DAC_SEL:
            cmds[n++] = bus_word(imds_pkg::CMD_WRITE, DAC_SEL + {5'd0, dac_idx, 1'b0},
                                 1'b0, 1'b0, 3'd0, 8'h00, 1'b0);
          imds_pkg::ST_DAC_OFFS: begin
            offs_byte = (dac_idx < 2'd3) ? d[40 + 8 * dac_idx +: 8] : 8'h00;
            cmds[n++] = bus_word(imds_pkg::CMD_WRITE, offs_byte, 1'b0, 1'b0, 3'd0, 8'h00,
                                 1'b0);
          end
          imds_pkg::ST_DAC_FIXED:
            cmds[n++] = bus_word(imds_pkg::CMD_WRITE, DAC_TAIL, 1'b0, 1'b0, 3'd0, 8'h00,
                                 1'b0);
          imds_pkg::ST_DAC_STOP: begin
            cmds[n++] = bus_word(imds_pkg::CMD_STOP, 8'h00, 1'b1, 1'b0, 3'd0, 8'h00, 1'b0);
            if (dac_idx < 2'd2) begin
              dac_idx   = dac_idx + 2'd1;
              seq_step  = imds_pkg::ST_DAC_ADDR;
              cmds[n++] = bus_word(imds_pkg::CMD_START, 8'h00, 1'b0, 1'b0, 3'd0, 8'h00,
                                   1'b0);
            end else begin
              dac_idx  = '0;
              seq_step = imds_pkg::ST_MOT_ADDR;
            end
          end
          default: begin
            seq_step = imds_pkg::ST_MOT_ADDR;
            wr_idx   = '0;
            rd_idx   = '0;
            cmds[n++] = bus_word(imds_pkg::CMD_STOP, 8'h00, 1'b1, 1'b0, 3'd0, 8'h00, 1'b0);
          end
        endcase
      end
    endcase
    cmds[n - 1].last = 1'b1;
  endfunction

  function automatic row_t stim_row(imds_pkg::op_t op, logic [63:0] d, int n = 0,
                                    imds_pkg::res_t t0 = '0, imds_pkg::res_t t1 = '0,
                                    imds_pkg::res_t t2 = '0);
    row_t r;
    r.op      = op;
    r.data    = d;
    r.n_typed = 2'(n);
    r.typed   = {t2, t1, t0};
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic offer_item(input row_t r);
    imds_pkg::res_t [2:0] cmds;
    int n;
    while (!steady && $urandom_range(0, 99) < 30) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.op;
    in_tdata  <= r.data;
    do @(posedge clk); while (!in_tready);
    sequence_bus_cmds(r.op, r.data, cmds, n);
    if (r.n_typed != 0) begin
      cmds = r.typed;
      n    = r.n_typed;
    end
    for (int i = 0; i < n; i++) expected_cmds.push_back(cmds[i]);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic rand_item(input imds_pkg::op_t op);
    offer_item(stim_row(op, {$urandom, $urandom}));
    rand_count++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (expected_cmds.size() != 0) @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_tready <= steady || ($urandom_range(0, 99) >= 30);
  end

  always @(posedge clk) begin
    imds_pkg::res_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      cmds_checked++;
      if (expected_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected bus command at %0t: data=%06h last=%0b", $realtime,
                   out_tdata, out_tlast);
      end else begin
        exp_r = expected_cmds.pop_front();
        if (out_tdata[2:0] !== exp_r.cmd || out_tdata[10:3] !== exp_r.tx ||
            out_tdata[11] !== exp_r.reload || out_tdata[12] !== exp_r.stored ||
            out_tdata[15:13] !== exp_r.slot || out_tdata[23:16] !== exp_r.value ||
            out_tlast !== exp_r.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch at %0t: expected cmd=%0d tx=%02h reload=%0b stored=%0b ",
                      "slot=%0d value=%02h last=%0b, got cmd=%0d tx=%02h reload=%0b ",
                      "stored=%0b slot=%0d value=%02h last=%0b"}, $realtime,
                     exp_r.cmd, exp_r.tx, exp_r.reload, exp_r.stored, exp_r.slot,
                     exp_r.value, exp_r.last, out_tdata[2:0], out_tdata[10:3],
                     out_tdata[11], out_tdata[12], out_tdata[15:13], out_tdata[23:16],
                     out_tlast);
        end
      end
    end
  end

  initial begin
    int kind;
    int cnt;
    logic [63:0] d;

    // Directed table: the first event after reset, the reset command, a full motor pass
    // with all-zero and all-one bytes, one DAC channel, and a reset in the middle.
    dir_rows.push_back(stim_row(imds_pkg::OP_EVENT, DATA_A, 1,
      bus_word(imds_pkg::CMD_WRITE, MOTOR_WR_ADDR, 1'b0, 1'b0, 3'd0, 8'h00, 1'b1)));
    dir_rows.push_back(stim_row(imds_pkg::OP_RESET, DATA_B, 3,
      bus_word(imds_pkg::CMD_STOP, 8'h00, 1'b0, 1'b0, 3'd0, 8'h00, 1'b0),
      bus_word(imds_pkg::CMD_START, 8'h00, 1'b0, 1'b0, 3'd0, 8'h00, 1'b0),
      bus_word(imds_pkg::CMD_WRITE, 8'h00, 1'b0, 1'b0, 3'd0, 8'h00, 1'b1)));
    dir_rows.push_back(stim_row(imds_pkg::OP_MOTOR, '1, 1,
      bus_word(imds_pkg::CMD_START, 8'h00, 1'b0, 1'b0, 3'd0, 8'h00, 1'b1)));
    for (int i = 0; i < 16; i++) begin
      d = (i % 2 == 1) ? '1 : ((i % 4 == 0) ? '0 : DATA_A);
      dir_rows.push_back(stim_row(imds_pkg::OP_EVENT, d));
    end
    dir_rows.push_back(stim_row(imds_pkg::OP_DAC, DATA_B, 1,
      bus_word(imds_pkg::CMD_START, 8'h00, 1'b0, 1'b0, 3'd0, 8'h00, 1'b1)));
    for (int i = 0; i < 5; i++)
      dir_rows.push_back(stim_row(imds_pkg::OP_EVENT, (i % 2) ? '0 : '1));
    dir_rows.push_back(stim_row(imds_pkg::OP_RESET, '0, 3,
      bus_word(imds_pkg::CMD_STOP, 8'h00, 1'b0, 1'b0, 3'd0, 8'h00, 1'b0),
      bus_word(imds_pkg::CMD_START, 8'h00, 1'b0, 1'b0, 3'd0, 8'h00, 1'b0),
      bus_word(imds_pkg::CMD_WRITE, 8'h00, 1'b0, 1'b0, 3'd0, 8'h00, 1'b1)));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) offer_item(dir_rows[i]);
    motor_passes++;
    wait_drained();

    // Mostly complete passes with random content; the rest is broken passes and noise.
    while (rand_count < RANDOM_ITEMS) begin
      steady = (rand_count >= 120 && rand_count < 200);
      kind   = $urandom_range(0, 9);
      if (kind <= 3) begin
        rand_item(imds_pkg::OP_MOTOR);
        repeat (16) rand_item(imds_pkg::OP_EVENT);
        motor_passes++;
      end else if (kind <= 6) begin
        rand_item(imds_pkg::OP_DAC);
        repeat (15) rand_item(imds_pkg::OP_EVENT);
        dac_passes++;
      end else if (kind == 7) begin
        rand_item($urandom_range(0, 1) ? imds_pkg::OP_MOTOR : imds_pkg::OP_DAC);
        cnt = $urandom_range(0, 12);
        repeat (cnt) rand_item(imds_pkg::OP_EVENT);
        rand_item(imds_pkg::OP_RESET);
      end else if (kind == 8) begin
        cnt = $urandom_range(1, 6);
        repeat (cnt) rand_item(imds_pkg::op_t'($urandom_range(0, 3)));
      end else begin
        wait_drained();
      end
    end
    steady = 1'b0;

    in_tvalid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Covered %0d items: %0d motor passes, %0d DAC passes, broken passes and noise.",
             items_sent, motor_passes, dac_passes);
    $display("Checked %0d bus commands, %0d mismatches.", cmds_checked, mismatches);
    if (mismatches == 0) begin
      $display("tb_i2c_motor_dac_sequencer_core passed");
    end else begin
      $display("tb_i2c_motor_dac_sequencer_core failed");
    end
    $finish;
  end

endmodule
